### src/rrts_pkg.sv
// ---------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

   localparam int TASKS_DEFAULT = 5;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_DELAY = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] delay_ticks;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  running_task;
      logic [31:0] tick_count;
      logic [3:0]  suspended_mask;
   } rsp_word_type;

   typedef enum logic [1:0] {
      SLOT_READY     = 2'd0,
      SLOT_RUNNING   = 2'd1,
      SLOT_SUSPENDED = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PREP,
      S_SEARCH,
      S_DONE
   } fsm_state_type;

   typedef struct packed {
      logic suspend;
      logic wake;
      logic demote;
      logic load;
      logic search;
      logic force_idle;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### src/round_robin_task_scheduler.sv
// ---------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler over TASKS slots with an always-ready idle task.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_data and raise start; the word is taken at an edge where busy
//   is low. operation tick advances the 32-bit counter, wakes sleepers due at
//   the new count and picks the next task; operation delay suspends the
//   running user task for delay_ticks ticks and picks again (ignored while
//   the idle task runs).
//   Exactly one result word follows each request: rsp_strobe is high for
//   one cycle with rsp_data holding running task, tick count and the mask
//   of suspended user tasks 0..3. The receiver cannot stall; the word must
//   be captured in that cycle.
//   Order: an accepted request passes through a prepare state, then a search
//   in which the token walks the ring of slot cells one cell per cycle, then
//   the done state that raises the strobe; an ignored delay goes straight to
//   the done state in the next cycle. One request is in flight at a time; the
//   next is taken the cycle after the strobe.
//   Reset (synchronous): counter zero, slot 0 running, all other slots
//   ready, no request in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int TASKS = TASKS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_data,
   output logic              rsp_strobe,
   output rsp_word_type      rsp_data
);

   localparam int             IW        = $clog2(TASKS);
   localparam logic [IW-1:0]  IDLE_SLOT = IW'(TASKS - 1);
   localparam int             MASK_BITS = (TASKS - 1 < 4) ? TASKS - 1 : 4;

   fsm_state_type state_ff, state_in;
   logic [31:0]   count_ff, count_in;
   logic [IW-1:0] run_ff, run_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] step_ff, step_in;
   logic          op_ff, op_in;
   logic [IW-1:0] start_slot;
   logic          accept;
   logic          found;
   logic          last_step;
   cell_ctrl_type ctrl;
   logic [TASKS-1:0] tok, hit, susp;
   logic [3:0]       mask;
   logic [IW+2:0]    run_wide;

   assign accept     = start && (state_ff == S_IDLE);
   assign found      = |hit;
   assign last_step  = (step_ff == IDLE_SLOT);
   assign start_slot = (run_ff == IDLE_SLOT) ? '0 : run_ff + 1'b1;

   always_comb begin
      ctrl            = '0;
      ctrl.suspend    = accept && req_data.operation == OP_DELAY && run_ff != IDLE_SLOT;
      ctrl.wake       = (state_ff == S_PREP) && op_ff == OP_TICK;
      ctrl.demote     = (state_ff == S_PREP);
      ctrl.load       = (state_ff == S_PREP);
      ctrl.search     = (state_ff == S_SEARCH);
      ctrl.force_idle = (state_ff == S_SEARCH) && !found && last_step;
   end

   genvar g;
   generate
      for (g = 0; g < TASKS; g++) begin : g_cell
         rrts_cell #(
            .TASKS (TASKS),
            .INDEX (g)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .sel_slot    (run_ff),
            .start_slot  (start_slot),
            .tick_count  (count_ff),
            .delay_ticks (req_data.delay_ticks),
            .tok_prev    (tok[(g + TASKS - 1) % TASKS]),
            .tok_out     (tok[g]),
            .hit         (hit[g]),
            .suspended   (susp[g])
         );
      end
      for (g = 0; g < 4; g++) begin : g_mask
         if (g < MASK_BITS) begin : g_on
            assign mask[g] = susp[g];
         end else begin : g_off
            assign mask[g] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.operation == OP_DELAY && run_ff == IDLE_SLOT) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP:   state_in = S_SEARCH;
         S_SEARCH: begin
            if (found || last_step) begin
               state_in = S_DONE;
            end
         end
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy       = (state_ff != S_IDLE);
      rsp_strobe = (state_ff == S_DONE);
   end

   always_comb begin
      count_in = count_ff;
      run_in   = run_ff;
      scan_in  = scan_ff;
      step_in  = step_ff;
      op_in    = op_ff;
      if (accept) begin
         op_in = req_data.operation;
         if (req_data.operation == OP_TICK) begin
            count_in = count_ff + 32'd1;
         end
      end
      if (state_ff == S_PREP) begin
         scan_in = start_slot;
         step_in = '0;
      end
      if (state_ff == S_SEARCH) begin
         if (found) begin
            run_in = scan_ff;
         end else if (last_step) begin
            run_in = IDLE_SLOT;
         end else begin
            scan_in = (scan_ff == IDLE_SLOT) ? '0 : scan_ff + 1'b1;
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         run_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      step_ff <= step_in;
      op_ff   <= op_in;
   end

   assign run_wide = {3'b000, run_ff};

   always_comb begin
      rsp_data.running_task   = run_wide[2:0];
      rsp_data.tick_count     = count_ff;
      rsp_data.suspended_mask = mask;
   end

endmodule

`default_nettype wire

### src/rrts_cell.sv
// ---------------------------------------------------------------------------
// rrts_cell
// One task slot: its state, its wake time and one stage of the search ring.
// ---------------------------------------------------------------------------
`default_nettype none

module rrts_cell
   import rrts_pkg::*;
#(
   parameter int TASKS = TASKS_DEFAULT,
   parameter int INDEX = 0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cell_ctrl_type             ctrl,
   input  wire logic [$clog2(TASKS)-1:0]  sel_slot,
   input  wire logic [$clog2(TASKS)-1:0]  start_slot,
   input  wire logic [31:0]               tick_count,
   input  wire logic [15:0]               delay_ticks,
   input  wire logic                      tok_prev,
   output logic                           tok_out,
   output logic                           hit,
   output logic                           suspended
);

   localparam int  IW      = $clog2(TASKS);
   localparam logic IS_IDLE = (INDEX == TASKS - 1);

   slot_state_type state_ff, state_in;
   logic           tok_ff, tok_in;
   logic [31:0]    wake_ff, wake_in;
   logic           selected;

   assign selected  = (sel_slot == IW'(INDEX));
   assign hit       = tok_ff && (state_ff == SLOT_READY);
   assign tok_out   = tok_ff;
   assign suspended = (state_ff == SLOT_SUSPENDED);

   always_comb begin
      state_in = state_ff;
      tok_in   = tok_ff;
      wake_in  = wake_ff;
      if (ctrl.suspend && selected) begin
         state_in = SLOT_SUSPENDED;
         wake_in  = tick_count + {16'd0, delay_ticks};
      end
      if (ctrl.wake && state_ff == SLOT_SUSPENDED && wake_ff == tick_count) begin
         state_in = SLOT_READY;
      end
      if (ctrl.demote && selected && !IS_IDLE && state_ff != SLOT_SUSPENDED) begin
         state_in = SLOT_READY;
      end
      if (ctrl.load) begin
         tok_in = (start_slot == IW'(INDEX));
      end
      if (ctrl.search) begin
         tok_in = tok_prev;
         if (hit) begin
            state_in = SLOT_RUNNING;
         end
      end
      if (ctrl.force_idle && IS_IDLE) begin
         state_in = SLOT_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= (INDEX == 0) ? SLOT_RUNNING : SLOT_READY;
         tok_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff <= wake_in;
   end

endmodule

`default_nettype wire
